### sv/gddn_pkg.sv
// shared types, constants and calendar tables for the date difference block
package gddn_pkg;

    // field widths
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 12;
    localparam int DIFF_W  = 21;
    localparam int COUNT_W = 20;
    localparam int PART_W  = 11;
    localparam int MSTART_W = 9;
    localparam int Q100_W  = 6;
    localparam int LEAPS_W = 10;
    localparam int MUL_W   = 13;
    localparam int PROD_W  = YEAR_W + MUL_W;

    // calendar constants
    localparam logic [YEAR_W-1:0]  EPOCH_YEAR  = 12'd1582;
    localparam logic [PART_W-1:0]  LEAPS_BEFORE_EPOCH = 11'd383;
    localparam logic [8:0]         DAYS_PER_YEAR = 9'd365;
    localparam logic [6:0]         YEARS_PER_CENTURY = 7'd100;
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
    localparam logic [DAY_W-1:0]   DAY_FEB_LEAP = 5'd29;

    // floor(n / 100) for n below 4096 as (n * 5243) >> 19
    localparam logic [MUL_W-1:0] DIV100_MUL   = 13'd5243;
    localparam int               DIV100_SHIFT = 19;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    // one calendar date
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } t_date;

    // per-stage advance enables
    typedef struct packed {
        logic en3;
        logic en2;
        logic en1;
    } t_stage_en;

    // days in a month of a common year, zero for a bad month code
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] v;
        case (m)
            4'd1:    v = 5'd31;
            4'd2:    v = 5'd28;
            4'd3:    v = 5'd31;
            4'd4:    v = 5'd30;
            4'd5:    v = 5'd31;
            4'd6:    v = 5'd30;
            4'd7:    v = 5'd31;
            4'd8:    v = 5'd31;
            4'd9:    v = 5'd30;
            4'd10:   v = 5'd31;
            4'd11:   v = 5'd30;
            4'd12:   v = 5'd31;
            default: v = 5'd0;
        endcase
        return v;
    endfunction

    // days before the first of a month in a common year
    function automatic logic [MSTART_W-1:0] month_start(input logic [MONTH_W-1:0] m);
        logic [MSTART_W-1:0] v;
        case (m)
            4'd1:    v = 9'd0;
            4'd2:    v = 9'd31;
            4'd3:    v = 9'd59;
            4'd4:    v = 9'd90;
            4'd5:    v = 9'd120;
            4'd6:    v = 9'd151;
            4'd7:    v = 9'd181;
            4'd8:    v = 9'd212;
            4'd9:    v = 9'd243;
            4'd10:   v = 9'd273;
            4'd11:   v = 9'd304;
            4'd12:   v = 9'd334;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

### sv/gddn_day_count.sv
// three-stage day count, validity check and month length for one date
module gddn_day_count #(
    parameter int unsigned YEAR_MAX = 4095
) (
    input  logic                         i_clk,
    input  gddn_pkg::t_stage_en          i_en,
    input  gddn_pkg::t_date              i_date,
    output logic [gddn_pkg::COUNT_W-1:0] o_count,
    output logic                         o_valid,
    output logic [gddn_pkg::DAY_W-1:0]   o_dim
);

    // stage 1 registers
    logic [gddn_pkg::DAY_W-1:0]    r1_day;
    logic [gddn_pkg::YEAR_W-1:0]   r1_year;
    logic [gddn_pkg::Q100_W-1:0]   r1_q100;
    logic                          r1_ok;
    logic                          r1_feb;
    logic                          r1_after_feb;
    logic [gddn_pkg::MSTART_W-1:0] r1_mstart;
    logic [gddn_pkg::DAY_W-1:0]    r1_mlen;

    // stage 2 registers
    logic [gddn_pkg::COUNT_W-1:0]  r2_base;
    logic [gddn_pkg::PART_W-1:0]   r2_part;
    logic                          r2_valid;
    logic [gddn_pkg::DAY_W-1:0]    r2_dim;

    // stage 3 registers
    logic [gddn_pkg::COUNT_W-1:0]  r3_count;
    logic                          r3_valid;
    logic [gddn_pkg::DAY_W-1:0]    r3_dim;

    // stage 1 logic
    logic [gddn_pkg::PROD_W-1:0]   n1_prod;
    logic                          n1_ok;

    // stage 2 logic
    logic [gddn_pkg::YEAR_W-1:0]   n2_hund;
    logic                          n2_leap;
    logic [gddn_pkg::LEAPS_W-1:0]  n2_leaps;
    logic [gddn_pkg::YEAR_W-1:0]   n2_yoff;
    logic [gddn_pkg::DIFF_W-1:0]   n2_base;
    logic [gddn_pkg::DAY_W-1:0]    n2_dim;
    logic [gddn_pkg::PART_W-1:0]   n2_part;
    logic                          n2_valid;

    // century quotient and range checks
    always_comb begin
        n1_prod = gddn_pkg::PROD_W'(i_date.year) * gddn_pkg::PROD_W'(gddn_pkg::DIV100_MUL);
        n1_ok   = (i_date.year >= gddn_pkg::EPOCH_YEAR)
               && (32'(i_date.year) <= YEAR_MAX)
               && (i_date.month >= gddn_pkg::MONTH_JAN)
               && (i_date.month <= gddn_pkg::MONTH_DEC);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en1) begin
            r1_day       <= i_date.day;
            r1_year      <= i_date.year;
            r1_q100      <= n1_prod[gddn_pkg::DIV100_SHIFT +: gddn_pkg::Q100_W];
            r1_ok        <= n1_ok;
            r1_feb       <= (i_date.month == gddn_pkg::MONTH_FEB);
            r1_after_feb <= (i_date.month > gddn_pkg::MONTH_FEB);
            r1_mstart    <= gddn_pkg::month_start(i_date.month);
            r1_mlen      <= gddn_pkg::month_len(i_date.month);
        end
    end

    // leap rule, leap count, year base and day-of-year part
    always_comb begin
        n2_hund  = gddn_pkg::YEAR_W'(r1_q100) * gddn_pkg::YEAR_W'(gddn_pkg::YEARS_PER_CENTURY);
        n2_leap  = (r1_year == n2_hund) ? (r1_q100[1:0] == 2'd0) : (r1_year[1:0] == 2'd0);
        n2_leaps = gddn_pkg::LEAPS_W'(r1_year >> 2)
                 - gddn_pkg::LEAPS_W'(r1_q100)
                 + gddn_pkg::LEAPS_W'(r1_q100 >> 2);
        n2_yoff  = r1_year - gddn_pkg::EPOCH_YEAR;
        n2_base  = gddn_pkg::DIFF_W'(n2_yoff) * gddn_pkg::DIFF_W'(gddn_pkg::DAYS_PER_YEAR);
        n2_dim   = (r1_feb && n2_leap) ? gddn_pkg::DAY_FEB_LEAP : r1_mlen;
        // leaps before this year = leaps up to this year minus this year
        n2_part  = gddn_pkg::PART_W'(r1_mstart)
                 + gddn_pkg::PART_W'(r1_day)
                 + gddn_pkg::PART_W'(r1_after_feb && n2_leap)
                 + gddn_pkg::PART_W'(n2_leaps)
                 - gddn_pkg::PART_W'(n2_leap)
                 - gddn_pkg::LEAPS_BEFORE_EPOCH;
        n2_valid = r1_ok && (r1_day >= gddn_pkg::DAY_FIRST) && (r1_day <= n2_dim);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en2) begin
            r2_base  <= n2_base[gddn_pkg::COUNT_W-1:0];
            r2_part  <= n2_part;
            r2_valid <= n2_valid;
            r2_dim   <= n2_dim;
        end
    end

    // final sum
    always_ff @(posedge i_clk) begin
        if (i_en.en3) begin
            r3_count <= r2_base + gddn_pkg::COUNT_W'(r2_part);
            r3_valid <= r2_valid;
            r3_dim   <= r2_dim;
        end
    end

    assign o_count = r3_count;
    assign o_valid = r3_valid;
    assign o_dim   = r3_dim;

endmodule

### sv/gregorian_date_diff_next_day_top.sv
// top level: date difference and next day, four-stage pipeline
//
//  channel  | dir | tdata (low bit up)                               | tuser
//  s_axis   | in  | a_day a_month a_year b_day b_month b_year, pad  | -
//  m_axis   | out | day_difference next_day next_month next_year, pad| status
//
// an input transfer passes through the four register stages (century quotient, leap and
// year multiply, day count sum, difference and next-date select) to output valid; one
// pair per cycle sustained while m_axis_tready is held high.
// reset clears only the stage valid bits; payload registers are not reset.
// each stage advances when it is empty or the stage after it advances, so a
// stall on m_axis holds every occupied stage and fills bubbles upstream.
module gregorian_date_diff_next_day_top #(
    parameter int unsigned YEAR_MAX = 4095
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // a_day, a_month, a_year, b_day, b_month, b_year, zero pad
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // day_difference, next_day, next_month, next_year, zero pad
    output logic [47:0] m_axis_tdata,
    // status
    output logic [1:0]  m_axis_tuser
);

    gddn_pkg::t_date     w_a_in;
    gddn_pkg::t_date     w_b_in;
    gddn_pkg::t_stage_en w_en;
    logic                w_en4;

    logic r_vld1, r_vld2, r_vld3, r_vld4;
    logic n_vld1, n_vld2, n_vld3, n_vld4;

    gddn_pkg::t_date r_a1, r_a2, r_a3;

    logic [gddn_pkg::COUNT_W-1:0] w_a_count, w_b_count;
    logic                         w_a_valid, w_b_valid;
    logic [gddn_pkg::DAY_W-1:0]   w_a_dim, w_b_dim;

    logic [gddn_pkg::DIFF_W-1:0]  r_diff,  n_diff;
    gddn_pkg::t_date              r_next,  n_next;
    gddn_pkg::t_status            r_status, n_status;

    // unpack input fields
    always_comb begin
        w_a_in.day   = s_axis_tdata[4:0];
        w_a_in.month = s_axis_tdata[8:5];
        w_a_in.year  = s_axis_tdata[20:9];
        w_b_in.day   = s_axis_tdata[25:21];
        w_b_in.month = s_axis_tdata[29:26];
        w_b_in.year  = s_axis_tdata[41:30];
    end

    // stage enables, from the output back
    always_comb begin
        w_en4       = !r_vld4 || m_axis_tready;
        w_en.en3    = !r_vld3 || w_en4;
        w_en.en2    = !r_vld2 || w_en.en3;
        w_en.en1    = !r_vld1 || w_en.en2;
        n_vld1      = w_en.en1 ? s_axis_tvalid : r_vld1;
        n_vld2      = w_en.en2 ? r_vld1 : r_vld2;
        n_vld3      = w_en.en3 ? r_vld2 : r_vld3;
        n_vld4      = w_en4    ? r_vld3 : r_vld4;
    end

    assign s_axis_tready = w_en.en1;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else begin
            r_vld1 <= n_vld1;
            r_vld2 <= n_vld2;
            r_vld3 <= n_vld3;
            r_vld4 <= n_vld4;
        end
    end

    // date a travels alongside the count pipeline for the next-day step
    always_ff @(posedge i_clk) begin
        if (w_en.en1) r_a1 <= w_a_in;
        if (w_en.en2) r_a2 <= r_a1;
        if (w_en.en3) r_a3 <= r_a2;
    end

    gddn_day_count #(.YEAR_MAX(YEAR_MAX)) u_count_a (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_date  (w_a_in),
        .o_count (w_a_count),
        .o_valid (w_a_valid),
        .o_dim   (w_a_dim)
    );

    gddn_day_count #(.YEAR_MAX(YEAR_MAX)) u_count_b (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_date  (w_b_in),
        .o_count (w_b_count),
        .o_valid (w_b_valid),
        .o_dim   (w_b_dim)
    );

    // difference and next-date select
    always_comb begin
        n_diff   = gddn_pkg::DIFF_W'(w_a_count) - gddn_pkg::DIFF_W'(w_b_count);
        n_next   = r_a3;
        n_status = gddn_pkg::ST_OK;
        if (!w_a_valid || !w_b_valid) begin
            n_diff   = '0;
            n_status = gddn_pkg::ST_INVALID;
        end else if (r_a3.day < w_a_dim) begin
            n_next.day = r_a3.day + gddn_pkg::DAY_FIRST;
        end else if (r_a3.month < gddn_pkg::MONTH_DEC) begin
            n_next.day   = gddn_pkg::DAY_FIRST;
            n_next.month = r_a3.month + gddn_pkg::MONTH_JAN;
        end else if (32'(r_a3.year) < YEAR_MAX) begin
            n_next.day   = gddn_pkg::DAY_FIRST;
            n_next.month = gddn_pkg::MONTH_JAN;
            n_next.year  = r_a3.year + gddn_pkg::YEAR_W'(1);
        end else begin
            n_status = gddn_pkg::ST_OVERFLOW;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r_diff   <= n_diff;
            r_next   <= n_next;
            r_status <= n_status;
        end
    end

    assign m_axis_tvalid = r_vld4;
    assign m_axis_tdata  = {6'd0, r_next.year, r_next.month, r_next.day, r_diff};
    assign m_axis_tuser  = r_status;

    // invalid results carry a zero difference
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == gddn_pkg::ST_INVALID)) |-> (m_axis_tdata[20:0] == '0))
        else $error("invalid result with nonzero difference");

    // overflow only on december 31 of the top year
    a_overflow_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == gddn_pkg::ST_OVERFLOW)) |->
        ((32'(m_axis_tdata[41:30]) == YEAR_MAX) && (m_axis_tdata[29:26] == gddn_pkg::MONTH_DEC)
         && (m_axis_tdata[25:21] == 5'd31)))
        else $error("overflow status on a date other than the last day");

    // an input transfer always lands in the first stage
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_vld1)
        else $error("accepted item lost at stage one");

    // a stalled output stage stays occupied and keeps an occupied third stage occupied
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld4 && !m_axis_tready && r_vld3) |=> (r_vld4 && r_vld3))
        else $error("stage dropped during output stall");

    // a valid second date always sits in a month of at least 28 days
    a_b_month_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld3 && w_b_valid) |-> (w_b_dim >= 5'd28))
        else $error("valid date with a short month length");

endmodule

### bench/gregorian_date_diff_next_day_top_tb.sv
// testbench for the date difference and next day block: calendar predictor, random traffic
`timescale 1ns / 1ps

module gregorian_date_diff_next_day_top_tb;

    // one predicted result transfer
    typedef struct {
        logic [gddn_pkg::DIFF_W-1:0]  diff;
        logic [gddn_pkg::DAY_W-1:0]   day;
        logic [gddn_pkg::MONTH_W-1:0] month;
        logic [gddn_pkg::YEAR_W-1:0]  year;
        gddn_pkg::t_status            status;
    } t_next_date;

    localparam int unsigned TOP_YEAR = 4095;
    localparam int unsigned FIRST_YEAR = 1582;
    localparam int unsigned MAX_WAIT = 13;
    localparam int          DATE_W = $bits(gddn_pkg::t_date);

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // a_day, a_month, a_year, b_day, b_month, b_year, zero pad
    logic [47:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // day_difference, next_day, next_month, next_year, zero pad
    logic [47:0] m_axis_tdata;
    // status
    logic [1:0]  m_axis_tuser;

    t_next_date pending_dates[$];
    int         error_count = 0;
    bit         no_idle = 1'b0;

    gregorian_date_diff_next_day_top #(.YEAR_MAX(TOP_YEAR)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    always #1 i_clk = ~i_clk;

    // calendar helpers
    function automatic bit leap_year(int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned month_days(int unsigned m, int unsigned y);
        int unsigned n;
        case (m)
            2:           n = leap_year(y) ? 29 : 28;
            4, 6, 9, 11: n = 30;
            1, 3, 5, 7, 8, 10, 12: n = 31;
            default:     n = 0;
        endcase
        return n;
    endfunction

    function automatic bit date_ok(gddn_pkg::t_date dt);
        if (dt.year < FIRST_YEAR || dt.year > TOP_YEAR)
            return 1'b0;
        return dt.day >= 1 && dt.day <= month_days(dt.month, dt.year);
    endfunction

    // leap years in 1..n
    function automatic int leaps_through(int n);
        return n / 4 - n / 100 + n / 400;
    endfunction

    // day number from the start of the first year, one for its first day, valid date assumed
    function automatic int days_from_epoch(gddn_pkg::t_date dt);
        int total;
        total = (int'(dt.year) - FIRST_YEAR) * 365 + int'(dt.day);
        total += leaps_through(int'(dt.year) - 1) - leaps_through(FIRST_YEAR - 1);
        for (int k = 1; k < dt.month; k++)
            total += month_days(k, dt.year);
        return total;
    endfunction

    // expected result for one date pair
    function automatic t_next_date predict_next_date(gddn_pkg::t_date a, gddn_pkg::t_date b);
        t_next_date r;
        r.diff = '0;
        r.day = a.day;
        r.month = a.month;
        r.year = a.year;
        r.status = gddn_pkg::ST_OK;
        if (!date_ok(a) || !date_ok(b)) begin
            r.status = gddn_pkg::ST_INVALID;
        end else begin
            r.diff = gddn_pkg::DIFF_W'(days_from_epoch(a) - days_from_epoch(b));
            if (a.day < month_days(a.month, a.year)) begin
                r.day = a.day + 1'b1;
            end else if (a.month < 12) begin
                r.day = 1;
                r.month = a.month + 1'b1;
            end else if (a.year < TOP_YEAR) begin
                r.day = 1;
                r.month = 1;
                r.year = a.year + 1'b1;
            end else begin
                r.status = gddn_pkg::ST_OVERFLOW;
            end
        end
        return r;
    endfunction

    function automatic gddn_pkg::t_date mk_date(int unsigned y, int unsigned m, int unsigned d);
        gddn_pkg::t_date dt;
        dt.year = gddn_pkg::YEAR_W'(y);
        dt.month = gddn_pkg::MONTH_W'(m);
        dt.day = gddn_pkg::DAY_W'(d);
        return dt;
    endfunction

    // valid date, weighted toward year edges, centuries and month ends
    function automatic gddn_pkg::t_date rand_calendar_date();
        int unsigned y;
        int unsigned m;
        int unsigned d;
        int unsigned len;
        case ($urandom_range(0, 9))
            0:       y = FIRST_YEAR + $urandom_range(0, 20);
            1:       y = TOP_YEAR - $urandom_range(0, 20);
            2:       y = 1600 + 100 * $urandom_range(0, 24);
            default: y = $urandom_range(FIRST_YEAR, TOP_YEAR);
        endcase
        m = $urandom_range(1, 12);
        len = month_days(m, y);
        case ($urandom_range(0, 5))
            0:       d = len;
            1:       d = len - 1;
            default: d = $urandom_range(1, len);
        endcase
        if ($urandom_range(0, 39) == 0) begin
            m = 12;
            d = 31;
        end
        return mk_date(y, m, d);
    endfunction

    // raw field noise, a valid date broken in one field, or the valid date unchanged
    function automatic gddn_pkg::t_date rand_noise_date();
        gddn_pkg::t_date dt;
        int unsigned len;
        dt = rand_calendar_date();
        len = month_days(dt.month, dt.year);
        case ($urandom_range(0, 4))
            0: dt = DATE_W'($urandom_range(0, (1 << DATE_W) - 1));
            1: dt.day = (len < 31) ? gddn_pkg::DAY_W'($urandom_range(len + 1, 31)) : '0;
            2: dt.month = ($urandom_range(0, 1) == 0) ? '0
                        : gddn_pkg::MONTH_W'($urandom_range(13, 15));
            3: dt.year = gddn_pkg::YEAR_W'($urandom_range(0, FIRST_YEAR - 1));
            default: ;
        endcase
        return dt;
    endfunction

    // one input transfer, sender gap drawn per item
    task automatic send_pair(input gddn_pkg::t_date a, input gddn_pkg::t_date b);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'b0, b, a};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_dates.push_back(predict_next_date(a, b));
    endtask

    // receiver: stall drawn per result
    initial begin : result_sink
        int unsigned stall;
        @(posedge i_rst_n);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    task automatic compare_field(input string what, input longint want, input longint got);
        if (want != got) begin
            error_count++;
            $display("%0t %s: expected %0d actual %0d", $time, what, want, got);
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_next_date want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_dates.size() == 0) begin
                error_count++;
                $display("%0t unexpected result: expected none actual %h/%0d",
                         $time, m_axis_tdata, m_axis_tuser);
            end else begin
                want = pending_dates.pop_front();
                if ($isunknown({m_axis_tdata[41:0], m_axis_tuser})) begin
                    error_count++;
                    $display("%0t unknown bits: expected known actual %h/%b",
                             $time, m_axis_tdata, m_axis_tuser);
                end
                compare_field("day_difference", $signed(want.diff),
                              $signed(m_axis_tdata[20:0]));
                compare_field("next_day", want.day, m_axis_tdata[25:21]);
                compare_field("next_month", want.month, m_axis_tdata[29:26]);
                compare_field("next_year", want.year, m_axis_tdata[41:30]);
                compare_field("status", want.status, m_axis_tuser);
            end
        end
    end

    // field extremes, leap rules, rollovers, invalid and top-year cases
    task automatic test_directed();
        send_pair(mk_date(1582, 1, 1), mk_date(1582, 1, 1));
        send_pair(mk_date(4095, 12, 31), mk_date(1582, 1, 1));
        send_pair(mk_date(1582, 1, 1), mk_date(4095, 12, 31));
        send_pair(mk_date(2000, 2, 28), mk_date(1999, 3, 1));
        send_pair(mk_date(2000, 2, 29), mk_date(2000, 3, 1));
        send_pair(mk_date(1900, 2, 28), mk_date(1900, 3, 1));
        send_pair(mk_date(1900, 2, 29), mk_date(1900, 3, 1));
        send_pair(mk_date(2024, 2, 29), mk_date(2023, 2, 29));
        send_pair(mk_date(2023, 12, 31), mk_date(2024, 1, 1));
        send_pair(mk_date(2024, 4, 30), mk_date(2024, 1, 31));
        send_pair(mk_date(2024, 1, 31), mk_date(2024, 4, 30));
        send_pair(mk_date(2024, 3, 15), mk_date(2024, 2, 15));
        send_pair(mk_date(2024, 3, 0), mk_date(2024, 3, 1));
        send_pair(mk_date(2024, 4, 31), mk_date(2024, 3, 1));
        send_pair(mk_date(2024, 0, 10), mk_date(2024, 3, 1));
        send_pair(mk_date(2024, 13, 10), mk_date(2024, 3, 1));
        send_pair(mk_date(2024, 3, 1), mk_date(2024, 15, 10));
        send_pair(mk_date(0, 6, 10), mk_date(2024, 3, 1));
        send_pair(mk_date(2024, 3, 1), mk_date(1581, 12, 31));
        send_pair(mk_date(4095, 31, 31), mk_date(4095, 15, 31));
        send_pair(mk_date(0, 0, 0), mk_date(0, 0, 0));
        send_pair(mk_date(4095, 12, 30), mk_date(4095, 12, 31));
        send_pair(mk_date(4094, 12, 31), mk_date(1600, 2, 29));
        send_pair(mk_date(4095, 12, 31), mk_date(2100, 2, 29));
    endtask

    // well-formed date pairs
    task automatic test_random_calendar(input int count);
        for (int i = 0; i < count; i++)
            send_pair(rand_calendar_date(), rand_calendar_date());
    endtask

    // invalid dates on either side, mixed with valid ones
    task automatic test_random_noise(input int count);
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 2))
                0:       send_pair(rand_noise_date(), rand_calendar_date());
                1:       send_pair(rand_calendar_date(), rand_noise_date());
                default: send_pair(rand_noise_date(), rand_noise_date());
            endcase
        end
    endtask

    // sender holds off until the pipeline has drained
    task automatic test_drain_pause();
        s_axis_tvalid <= 1'b0;
        while (pending_dates.size() != 0) @(posedge i_clk);
        repeat ($urandom_range(1, MAX_WAIT)) @(posedge i_clk);
    endtask

    // main sequence
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_calendar(150);
        test_drain_pause();
        no_idle = 1'b1;
        test_random_calendar(80);
        no_idle = 1'b0;
        test_random_noise(60);
        test_drain_pause();
        test_random_calendar(110);
        s_axis_tvalid <= 1'b0;
        while (pending_dates.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (error_count == 0)
            $display("gregorian_date_diff_next_day_top: match");
        else
            $display("gregorian_date_diff_next_day_top: mismatch");
        $finish;
    end

    // run limit
    initial begin
        #500000;
        $display("gregorian_date_diff_next_day_top: mismatch");
        $finish;
    end

endmodule
